/* hdl/fsq_pkg.sv */
package fsq_pkg;

   // Array geometry
   localparam int MEM_BYTES        = 131072;
   localparam int SECTOR_BYTES     = 4096;
   localparam int CHIP_ERASE_BYTES = 65536;
   localparam int ADDR_W           = $clog2(MEM_BYTES);
   localparam int ADDR_IN_W        = 17;
   localparam int DATA_W           = 8;
   localparam int WIDE_W           = ADDR_IN_W + 1;

   // Unlock addresses and command bytes
   localparam logic [15:0] UNLOCK_ADDR_A = 16'h5555;
   localparam logic [15:0] UNLOCK_ADDR_B = 16'h2AAA;
   localparam logic [7:0]  CMD_UNLOCK_A  = 8'hAA;
   localparam logic [7:0]  CMD_UNLOCK_B  = 8'h55;
   localparam logic [7:0]  CMD_AUTOSEL   = 8'h90;
   localparam logic [7:0]  CMD_ERASE     = 8'h80;
   localparam logic [7:0]  CMD_RESET     = 8'hF0;
   localparam logic [7:0]  CMD_PROGRAM   = 8'hA0;
   localparam logic [7:0]  CMD_SECTOR    = 8'h30;
   localparam logic [7:0]  CMD_CHIP      = 8'h10;
   localparam logic [7:0]  ERASED_BYTE   = 8'hFF;

   typedef logic [ADDR_W-1:0] addr_type;

   typedef struct packed {
      logic     start;
      addr_type base;
      addr_type last;
   } sweep_cmd_type;

   typedef struct packed {
      logic     busy;
      logic     done;
      addr_type addr;
   } sweep_stat_type;

   typedef struct packed {
      logic              prog_en;
      logic              erase;
      logic              sector;
      logic              from_array;
      logic [DATA_W-1:0] rbyte;
   } cmd_act_type;

endpackage

/* hdl/fsq_if.sv */
interface fsq_req_if import fsq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [ADDR_IN_W-1:0] address;
   logic [DATA_W-1:0]    wdata;

   modport source (output valid, output mode, output address, output wdata, input ready);
   modport sink   (input valid, input mode, input address, input wdata, output ready);
endinterface

interface fsq_rsp_if import fsq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] rdata;

   modport source (output valid, output rdata, input ready);
   modport sink   (input valid, input rdata, output ready);
endinterface

/* hdl/fsq_ram.sv */
module fsq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/fsq_sweep.sv */
module fsq_sweep import fsq_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  sweep_cmd_type  cmd,
   output sweep_stat_type stat
);

   logic     busy_ff, busy_in;
   addr_type addr_ff, addr_in;
   addr_type last_ff, last_in;
   logic     done;

   assign done = busy_ff && (addr_ff == last_ff);

   always_comb begin
      busy_in = busy_ff;
      addr_in = addr_ff;
      last_in = last_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         addr_in = cmd.base;
         last_in = cmd.last;
      end else if (busy_ff) begin
         if (done) begin
            busy_in = 1'b0;
         end else begin
            addr_in = addr_ff + 1'b1;
         end
      end
   end

   // Reset starts a pass over the whole array
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         addr_ff <= '0;
         last_ff <= ADDR_W'(MEM_BYTES - 1);
      end else begin
         busy_ff <= busy_in;
         addr_ff <= addr_in;
         last_ff <= last_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done;
   assign stat.addr = addr_ff;

endmodule

/* hdl/fsq_cmd.sv */
module fsq_cmd import fsq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic              is_write,
   input  addr_type          addr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [DATA_W-1:0] mfr_id,
   input  logic [DATA_W-1:0] dev_id,
   output cmd_act_type       act
);

   localparam logic [3:0] CS_READ    = 4'd0;
   localparam logic [3:0] CS_UNLOCK1 = 4'd1;
   localparam logic [3:0] CS_UNLOCK2 = 4'd2;
   localparam logic [3:0] CS_AUTOSEL = 4'd3;
   localparam logic [3:0] CS_SETUP1  = 4'd4;
   localparam logic [3:0] CS_SETUP2  = 4'd5;
   localparam logic [3:0] CS_SETUP3  = 4'd6;
   localparam logic [3:0] CS_PROGRAM = 4'd8;

   localparam logic [1:0] RS_READ    = 2'd0;
   localparam logic [1:0] RS_AUTOSEL = 2'd1;
   localparam logic [1:0] RS_ERASED  = 2'd2;

   logic [3:0] cmd_ff, cmd_in;
   logic [1:0] rd_ff, rd_in;
   logic       at_a, at_b;

   assign at_a = (addr == ADDR_W'(UNLOCK_ADDR_A));
   assign at_b = (addr == ADDR_W'(UNLOCK_ADDR_B));

   always_comb begin
      cmd_in         = cmd_ff;
      rd_in          = rd_ff;
      act.prog_en    = 1'b0;
      act.erase      = 1'b0;
      act.sector     = 1'b0;
      act.from_array = 1'b0;
      act.rbyte      = '0;
      if (!is_write) begin
         case (rd_ff)
            RS_READ: begin
               act.from_array = 1'b1;
            end
            RS_AUTOSEL: begin
               if (addr[7:0] == 8'd0) begin
                  act.rbyte = mfr_id;
               end else if (addr[7:0] == 8'd1) begin
                  act.rbyte = dev_id;
               end
            end
            default: begin
               act.rbyte = ERASED_BYTE;
               cmd_in    = CS_READ;
               rd_in     = RS_READ;
            end
         endcase
      end else begin
         case (cmd_ff)
            CS_READ: begin
               if (at_a && wdata == CMD_UNLOCK_A) cmd_in = CS_UNLOCK1;
            end
            CS_UNLOCK1: begin
               // Failed unlock keeps the read state
               cmd_in = (at_b && wdata == CMD_UNLOCK_B) ? CS_UNLOCK2 : CS_READ;
            end
            CS_UNLOCK2: begin
               if (at_a && wdata == CMD_AUTOSEL) begin
                  cmd_in = CS_AUTOSEL;
                  rd_in  = RS_AUTOSEL;
               end else if (at_a && wdata == CMD_ERASE) begin
                  cmd_in = CS_SETUP1;
               end else if (at_a && wdata == CMD_PROGRAM) begin
                  cmd_in = CS_PROGRAM;
               end else begin
                  cmd_in = CS_READ;
                  rd_in  = RS_READ;
               end
            end
            CS_SETUP1: begin
               if (at_a && wdata == CMD_UNLOCK_A) begin
                  cmd_in = CS_SETUP2;
               end else begin
                  cmd_in = CS_READ;
                  rd_in  = RS_READ;
               end
            end
            CS_SETUP2: begin
               if (at_b && wdata == CMD_UNLOCK_B) begin
                  cmd_in = CS_SETUP3;
               end else begin
                  cmd_in = CS_READ;
                  rd_in  = RS_READ;
               end
            end
            CS_SETUP3: begin
               // Stay in the erase step so a repeated command erases again
               if (wdata == CMD_SECTOR) begin
                  act.erase  = 1'b1;
                  act.sector = 1'b1;
                  rd_in      = RS_ERASED;
               end else if (wdata == CMD_CHIP) begin
                  act.erase  = 1'b1;
                  rd_in      = RS_ERASED;
               end else begin
                  cmd_in = CS_READ;
                  rd_in  = RS_READ;
               end
            end
            CS_AUTOSEL: begin
               if (wdata != CMD_RESET && at_a && wdata == CMD_UNLOCK_A) begin
                  cmd_in = CS_UNLOCK1;
               end else begin
                  cmd_in = CS_READ;
                  rd_in  = RS_READ;
               end
            end
            CS_PROGRAM: begin
               act.prog_en = 1'b1;
               cmd_in      = CS_READ;
               rd_in       = RS_READ;
            end
            default: begin
               cmd_in = CS_READ;
               rd_in  = RS_READ;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff <= CS_READ;
         rd_ff  <= RS_READ;
      end else if (fire) begin
         cmd_ff <= cmd_in;
         rd_ff  <= rd_in;
      end
   end

endmodule

/* hdl/flash_command_sequencer.sv */
// Byte-wide flash save memory with an unlock-sequence command decoder. Each
// request transaction is one bus access: a read (mode 0) returns one rdata
// response, a write (mode 1) returns nothing and steps the command sequence.
// After a write the block is ready for the next request straight away unless
// the write started an erase. A read passes through the registered array read
// and then the response register, and the request side stays closed until that
// response is taken. Sector erase (one SECTOR_BYTES sector) and chip erase (the
// first min(CHIP_ERASE_BYTES, MEM_BYTES) bytes) occupy the block while they run;
// both run on the address counter that writes zero into the array one byte per
// cycle through its single write port. After reset the same counter clears the
// whole array before the first request is taken; configuration writes are
// accepted throughout. Registers: large_size at byte address 0, manufacturer_id
// at 4, device_id at 8.
module flash_command_sequencer import fsq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   fsq_req_if.sink          req,
   fsq_rsp_if.source        rsp,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic [1:0] ST_SWEEP = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;

   localparam logic [1:0] REG_LARGE_SIZE = 2'd0;
   localparam logic [1:0] REG_MFR_ID     = 2'd1;
   localparam logic [1:0] REG_DEV_ID     = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              sel_array_ff;
   logic [DATA_W-1:0] rbyte_ff;
   logic              large_ff;
   logic [DATA_W-1:0] mfr_ff;
   logic [DATA_W-1:0] dev_ff;

   logic              fire;
   logic              csr_wr;
   logic [WIDE_W-1:0] addr_wide;
   addr_type          addr_map;
   cmd_act_type       act;
   sweep_cmd_type     sweep_cmd;
   sweep_stat_type    sweep_stat;
   logic [WIDE_W-1:0] sec_base;
   logic [WIDE_W-1:0] sec_end;
   logic [WIDE_W-1:0] end_sel;
   logic              ram_wr_en;
   addr_type          ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic [DATA_W-1:0] ram_rd_data;

   // ---------------------------------------------------------------------
   // Configuration port: writes land on the access phase, reads are direct
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         large_ff <= 1'b0;
         mfr_ff   <= 8'd50;
         dev_ff   <= 8'd27;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_LARGE_SIZE: large_ff <= csr_pwdata[0];
            REG_MFR_ID:     mfr_ff   <= csr_pwdata[DATA_W-1:0];
            REG_DEV_ID:     dev_ff   <= csr_pwdata[DATA_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_LARGE_SIZE: csr_prdata = {31'd0, large_ff};
         REG_MFR_ID:     csr_prdata = {24'd0, mfr_ff};
         REG_DEV_ID:     csr_prdata = {24'd0, dev_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Address mapping: mask by size, then wrap once into the array
   // ---------------------------------------------------------------------
   assign addr_wide = large_ff ? {1'b0, req.address} : {2'b00, req.address[15:0]};
   assign addr_map  = (addr_wide >= WIDE_W'(MEM_BYTES))
                    ? ADDR_W'(addr_wide - WIDE_W'(MEM_BYTES))
                    : ADDR_W'(addr_wide);

   // Accept only in idle with the response register free
   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign fire      = req.valid && req.ready;

   fsq_cmd u_cmd (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .is_write (req.mode),
      .addr     (addr_map),
      .wdata    (req.wdata),
      .mfr_id   (mfr_ff),
      .dev_id   (dev_ff),
      .act      (act)
   );

   // ---------------------------------------------------------------------
   // Erase range: sector base from address bits 15:12, end clipped
   // ---------------------------------------------------------------------
   assign sec_base = {2'b00, addr_map[15:0]} & ~WIDE_W'(SECTOR_BYTES - 1);
   assign sec_end  = sec_base + WIDE_W'(SECTOR_BYTES);

   always_comb begin
      if (act.sector) begin
         end_sel = (sec_end > WIDE_W'(MEM_BYTES)) ? WIDE_W'(MEM_BYTES) : sec_end;
      end else begin
         end_sel = (CHIP_ERASE_BYTES > MEM_BYTES) ? WIDE_W'(MEM_BYTES)
                                                  : WIDE_W'(CHIP_ERASE_BYTES);
      end
   end

   assign sweep_cmd.start = fire && req.mode && act.erase;
   assign sweep_cmd.base  = act.sector ? ADDR_W'(sec_base) : '0;
   assign sweep_cmd.last  = ADDR_W'(end_sel - 1'b1);

   fsq_sweep u_sweep (
      .clock (clock),
      .reset (reset),
      .cmd   (sweep_cmd),
      .stat  (sweep_stat)
   );

   // ---------------------------------------------------------------------
   // Array: the sweep owns the write port while busy, else byte program
   // ---------------------------------------------------------------------
   always_comb begin
      if (sweep_stat.busy) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = sweep_stat.addr;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = fire && req.mode && act.prog_en;
         ram_wr_addr = addr_map;
         ram_wr_data = req.wdata;
      end
   end

   fsq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MEM_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (addr_map),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------
   // Sequencer and response register
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_SWEEP: begin
            if (sweep_stat.done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (fire && !req.mode) begin
               state_in = ST_READ;
            end else if (sweep_cmd.start) begin
               state_in = ST_SWEEP;
            end
         end
         ST_READ: begin
            // Array byte has arrived from the registered read
            rsp_valid_in = 1'b1;
            rsp_data_in  = sel_array_ff ? ram_rd_data : rbyte_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the response source decided at acceptance
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (fire) begin
         sel_array_ff <= act.from_array;
         rbyte_ff     <= act.rbyte;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.rdata = rsp_data_ff;

`ifndef ASSERT_OFF
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep_stat.busy |-> !req.ready)
      else $error("request accepted while array sweep is running");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_READ))
      else $error("response raised outside the read step");

   a_erase_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep_cmd.start |=> (sweep_stat.busy && state_ff == ST_SWEEP))
      else $error("erase command did not start the sweep");

   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (fire && req.mode) |=> !rsp_valid_ff)
      else $error("write transaction produced a response");

   a_read_goes_read: assert property (@(posedge clock) disable iff (reset)
      (fire && !req.mode) |=> (state_ff == ST_READ && !req.ready))
      else $error("read transaction did not enter the read step");
`endif

endmodule
